### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/pmp_pkg.sv
// ----------------------------------------------------------------------------
// Paged memory package
// Operation and fault codes and the queued command type.
// ----------------------------------------------------------------------------
package pmp_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_FETCH  = 3'd2,
    OP_DREAD  = 3'd3,
    OP_DWRITE = 3'd4,
    OP_MAP    = 3'd5,
    OP_NONE6  = 3'd6,
    OP_NONE7  = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    F_NONE      = 4'd0,
    F_RD_UNMAP  = 4'd1,
    F_RD_PROT   = 4'd2,
    F_WR_UNMAP  = 4'd3,
    F_WR_PROT   = 4'd4,
    F_FE_UNMAP  = 4'd5,
    F_FE_PROT   = 4'd6,
    F_DBG_UNMAP = 4'd7,
    F_EMPTY     = 4'd8,
    F_RANGE     = 4'd9
  } fault_t;

  localparam int unsigned FLAG_MAPPED = 3;
  localparam logic [2:0] PERM_R = 3'b001;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b100;
  localparam logic [2:0] PERM_RW = PERM_R | PERM_W;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t         op;
    logic [32:0] addr;
    logic [2:0]  count;
    logic [31:0] wdata;
    logic [2:0]  perms;
    logic        early;       // result known without touching memory
    fault_t      early_fault;
    logic [32:0] last;        // last byte of a map region
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_FLAGS,
    BS_BYTE,
    BS_MAP,
    BS_DONE
  } back_state_t;

endpackage

### rtl/core/paged_memory_with_permissions_core.sv
// ----------------------------------------------------------------------------
// Paged memory with permissions
// Channel   Handshake        Fields
// command   start / busy     operation address byte_count write_data
//                            region_size page_perms
// result    done strobe      read_data success fault bytes_done
//
// A byte access steps through a flags step and a byte step for each byte,
// then a done step; a region map writes one page flag per step, then a done
// step. The back end handles one command at a time and takes the next from
// the queue only once it is back in idle. After reset a sweep of one store
// byte per cycle clears all 2^ADDR_BITS store bytes and the page flags.
// The receiver cannot stall; busy rises while the command queue is full.
// ----------------------------------------------------------------------------
module paged_memory_with_permissions_core #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned ADDR_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] address,
  input  logic [2:0]  byte_count,
  input  logic [31:0] write_data,
  input  logic [31:0] region_size,
  input  logic [2:0]  page_perms,
  output logic        done,
  output logic [31:0] read_data,
  output logic        success,
  output logic [3:0]  fault,
  output logic [2:0]  bytes_done
);

  pmp_pkg::cmd_t push_cmd, head;
  logic push, pop, empty, full;

  assign busy = full;

  pmp_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .start, .full, .operation, .address, .byte_count,
    .write_data, .region_size, .page_perms, .push, .cmd(push_cmd)
  );

  pmp_queue u_queue (
    .clk, .rst, .push, .push_cmd, .pop, .empty, .full, .head
  );

  pmp_back #(.PAGE_BYTES(PAGE_BYTES), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst, .empty, .head, .pop, .done, .read_data, .success, .fault,
    .bytes_done
  );

endmodule

### rtl/core/pmp_front.sv
// ----------------------------------------------------------------------------
// Paged memory front end
// Accepts commands, clamps the byte count and settles map range checks and unused operations.
// ----------------------------------------------------------------------------
module pmp_front #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic             start,
  input  logic             full,
  input  logic [2:0]       operation,
  input  logic [31:0]      address,
  input  logic [2:0]       byte_count,
  input  logic [31:0]      write_data,
  input  logic [31:0]      region_size,
  input  logic [2:0]       page_perms,
  output logic             push,
  output pmp_pkg::cmd_t    cmd
);

  logic [32:0] last;
  logic        oor;

  // Last byte of the region and whether it lies beyond the store.
  assign last = {1'b0, address} + {1'b0, region_size} - 33'd1;
  assign oor  = (last >> ADDR_BITS) != 33'd0;
  assign push = start && !full;

  always_comb begin
    cmd.op          = pmp_pkg::op_t'(operation);
    cmd.addr        = {1'b0, address};
    cmd.count       = (byte_count > 3'd4) ? 3'd4 : byte_count;
    cmd.wdata       = write_data;
    cmd.perms       = page_perms;
    cmd.last        = last;
    cmd.early       = 1'b0;
    cmd.early_fault = pmp_pkg::F_NONE;
    unique case (pmp_pkg::op_t'(operation)) inside
      pmp_pkg::OP_MAP: begin
        cmd.early = (region_size == 32'd0) || oor;
        cmd.early_fault = (region_size == 32'd0) ? pmp_pkg::F_EMPTY :
                          oor ? pmp_pkg::F_RANGE : pmp_pkg::F_NONE;
      end
      pmp_pkg::OP_NONE6, pmp_pkg::OP_NONE7: cmd.early = 1'b1;
      default: cmd.early = 1'b0;
    endcase
  end

endmodule

### rtl/core/pmp_queue.sv
// ----------------------------------------------------------------------------
// Paged memory command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pmp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pmp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          empty,
  output logic          full,
  output pmp_pkg::cmd_t head
);

  pmp_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign head  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, full, !push)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, empty, !pop)
  `ASSERT_IMPLIES(a_fill_range, clk, rst, 1'b1, fill != 2'd3)

endmodule

### rtl/core/pmp_back.sv
// ----------------------------------------------------------------------------
// Paged memory back end
// Runs commands against the page flags and the byte store, byte by byte or page
// by page, and presents one result word per command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pmp_back #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned ADDR_BITS  = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  pmp_pkg::cmd_t head,
  output logic          pop,
  output logic          done,
  output logic [31:0]   read_data,
  output logic          success,
  output logic [3:0]    fault,
  output logic [2:0]    bytes_done
);

  localparam int unsigned     PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam longint unsigned STORE_BYTES = 64'd1 << ADDR_BITS;
  localparam int unsigned     PAGE_COUNT  =
    int'((STORE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES);
  localparam int unsigned PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned PAGE_WR     = (ADDR_BITS > PAGE_SHIFT) ? ADDR_BITS - PAGE_SHIFT : 1;
  localparam int unsigned CLR_W       = ADDR_BITS + 1;

  pmp_pkg::back_state_t state, state_next;

  // Page flags and byte store memories.
  logic [3:0] flag_mem [PAGE_COUNT];
  logic [7:0] byte_mem [STORE_BYTES];

  pmp_pkg::cmd_t    cur;
  logic [2:0]       idx;
  logic [31:0]      rdata;
  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;
  logic [PAGE_W-1:0] map_page;
  logic [3:0]       flag_q;
  logic [7:0]       byte_q;
  logic [32:0]      addr_i;
  logic             in_store;
  logic [PAGE_W-1:0] page_i;
  logic [PAGE_W-1:0] last_page;
  logic             flag_we;
  logic [PAGE_W-1:0] flag_waddr;
  logic [3:0]       flag_wdata;
  logic             byte_we;
  logic [ADDR_BITS-1:0] byte_waddr;
  logic [7:0]       byte_wdata;
  logic             step_fault;
  pmp_pkg::fault_t  step_code;
  logic             need_ok;
  logic [2:0]       need;
  pmp_pkg::fault_t  unm;

  assign addr_i    = cur.addr + {30'd0, idx};
  assign in_store  = (addr_i >> ADDR_BITS) == 33'd0;
  assign page_i    = PAGE_W'(addr_i[PAGE_WR+PAGE_SHIFT-1:PAGE_SHIFT]);
  assign last_page = PAGE_W'(cur.last[PAGE_WR+PAGE_SHIFT-1:PAGE_SHIFT]);
  assign clearing  = !clr_cnt[CLR_W-1];

  // Permission and fault code for checked accesses.
  always_comb begin
    need = pmp_pkg::PERM_R;
    unm  = pmp_pkg::F_RD_UNMAP;
    unique case (cur.op)
      pmp_pkg::OP_WRITE: begin need = pmp_pkg::PERM_W; unm = pmp_pkg::F_WR_UNMAP; end
      pmp_pkg::OP_FETCH: begin need = pmp_pkg::PERM_X; unm = pmp_pkg::F_FE_UNMAP; end
      default: begin need = pmp_pkg::PERM_R; unm = pmp_pkg::F_RD_UNMAP; end
    endcase
  end

  // Per-byte check in the byte step, on the flags read in the flags step.
  always_comb begin
    step_fault = 1'b0;
    step_code  = pmp_pkg::F_NONE;
    need_ok    = (flag_q[2:0] & need) != 3'd0;
    unique case (cur.op) inside
      pmp_pkg::OP_READ, pmp_pkg::OP_WRITE, pmp_pkg::OP_FETCH: begin
        if (!in_store || !flag_q[pmp_pkg::FLAG_MAPPED]) begin
          step_fault = 1'b1;
          step_code  = unm;
        end else if (!need_ok) begin
          step_fault = 1'b1;
          step_code  = pmp_pkg::fault_t'(unm + 4'd1);
        end
      end
      pmp_pkg::OP_DREAD: begin
        if (!in_store || !flag_q[pmp_pkg::FLAG_MAPPED]) begin
          step_fault = 1'b1;
          step_code  = pmp_pkg::F_DBG_UNMAP;
        end
      end
      pmp_pkg::OP_DWRITE: begin
        if (!in_store) begin
          step_fault = 1'b1;
          step_code  = pmp_pkg::F_RANGE;
        end
      end
      default: step_fault = 1'b0;
    endcase
  end

  // Next state, memory writes and handshake.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = page_i;
    flag_wdata = 4'd0;
    byte_we    = 1'b0;
    byte_waddr = addr_i[ADDR_BITS-1:0];
    byte_wdata = cur.wdata[8*idx[1:0] +: 8];
    if (clearing) begin
      flag_we    = 1'b1;
      flag_waddr = clr_cnt[PAGE_W-1:0];
      byte_we    = 1'b1;
      byte_waddr = clr_cnt[ADDR_BITS-1:0];
      byte_wdata = 8'd0;
    end
    unique case (state)
      pmp_pkg::BS_IDLE: begin
        if (!empty && !clearing) begin
          pop = 1'b1;
          state_next = head.early ? pmp_pkg::BS_DONE :
                       (head.op == pmp_pkg::OP_MAP) ? pmp_pkg::BS_MAP :
                       (head.count == 3'd0) ? pmp_pkg::BS_DONE : pmp_pkg::BS_FLAGS;
        end
      end
      pmp_pkg::BS_FLAGS: begin
        state_next = pmp_pkg::BS_BYTE;
      end
      pmp_pkg::BS_BYTE: begin
        if (step_fault) begin
          state_next = pmp_pkg::BS_DONE;
        end else begin
          if (cur.op == pmp_pkg::OP_WRITE || cur.op == pmp_pkg::OP_DWRITE) begin
            byte_we = 1'b1;
          end
          if (cur.op == pmp_pkg::OP_DWRITE) begin
            flag_we    = 1'b1;
            flag_wdata = (flag_q[2:0] == 3'd0) ? {1'b1, pmp_pkg::PERM_RW}
                                               : {1'b1, flag_q[2:0]};
          end
          state_next = (idx + 3'd1 == cur.count) ? pmp_pkg::BS_DONE : pmp_pkg::BS_FLAGS;
        end
      end
      pmp_pkg::BS_MAP: begin
        flag_we    = 1'b1;
        flag_waddr = map_page;
        flag_wdata = {1'b1, cur.perms};
        if (map_page == last_page) state_next = pmp_pkg::BS_DONE;
      end
      pmp_pkg::BS_DONE: begin
        state_next = pmp_pkg::BS_IDLE;
      end
      default: state_next = pmp_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pmp_pkg::BS_IDLE;
    else state <= state_next;
  end

  // Clearing sweep after reset: one byte of the store per cycle, with the
  // page flags cleared along the way.
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + CLR_W'(1);
  end

  // Flag memory with registered read.
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    flag_q <= flag_mem[page_i];
  end

  // Byte store with registered read.
  always_ff @(posedge clk) begin
    if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
    byte_q <= byte_mem[addr_i[ADDR_BITS-1:0]];
  end

  // Command register, byte index and result assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= (state == pmp_pkg::BS_DONE);
      if (pop) begin
        cur        <= head;
        idx        <= 3'd0;
        rdata      <= 32'd0;
        map_page   <= PAGE_W'(head.addr[PAGE_WR+PAGE_SHIFT-1:PAGE_SHIFT]);
        success    <= !head.early;
        fault      <= head.early_fault;
        bytes_done <= 3'd0;
      end
      if (state == pmp_pkg::BS_MAP) map_page <= map_page + PAGE_W'(1);
      if (state == pmp_pkg::BS_BYTE) begin
        if (step_fault) begin
          success <= 1'b0;
          fault   <= step_code;
        end else begin
          idx        <= idx + 3'd1;
          bytes_done <= idx + 3'd1;
          // The byte was fetched in the flags step just before.
          if (cur.op != pmp_pkg::OP_WRITE && cur.op != pmp_pkg::OP_DWRITE)
            rdata[8*idx[1:0] +: 8] <= byte_q;
        end
      end
      if (state == pmp_pkg::BS_DONE) read_data <= rdata;
    end
  end

  `ASSERT_IMPLIES(a_pop_idle, clk, rst, pop, state == pmp_pkg::BS_IDLE)
  `ASSERT_IMPLIES(a_idx_range, clk, rst, 1'b1, idx <= 3'd4)
  `ASSERT_NEXT(a_done_once, clk, rst, done, !done)

endmodule

### dv/paged_memory_with_permissions_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged memory checker
// Watches the command and result channels. It keeps its own model of the
// page flags and the byte store, and it predicts one result word for each
// accepted command word. Each result word is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module paged_memory_with_permissions_core_checker #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned ADDR_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] address,
  input  logic [2:0]  byte_count,
  input  logic [31:0] write_data,
  input  logic [31:0] region_size,
  input  logic [2:0]  page_perms,
  input  logic        done,
  input  logic [31:0] read_data,
  input  logic        success,
  input  logic [3:0]  fault,
  input  logic [2:0]  bytes_done,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam longint unsigned STORE_SIZE = 64'd1 << ADDR_BITS;
  localparam int unsigned NUM_PAGES = int'((STORE_SIZE + PAGE_BYTES - 1) / PAGE_BYTES);

  typedef struct packed {
    logic [31:0] rdata;
    logic        ok;
    logic [3:0]  flt;
    logic [2:0]  ndone;
  } access_result_t;

  logic [3:0] page_state [NUM_PAGES];
  logic [7:0] mem_bytes [STORE_SIZE];
  access_result_t expected_results [$];

  function automatic bit page_mapped(longint unsigned a);
    return a < STORE_SIZE && page_state[a / PAGE_BYTES][pmp_pkg::FLAG_MAPPED];
  endfunction

  // Apply one command word to the model and return its result word.
  function automatic access_result_t predict_access(pmp_pkg::op_t op, logic [31:0] base,
      logic [2:0] cnt_in, logic [31:0] wd, logic [31:0] sz, logic [2:0] pm);
    access_result_t r;
    int unsigned cnt;
    longint unsigned a, last, p;
    logic [2:0] need;
    logic [3:0] unm;
    r = '0;
    cnt = (cnt_in > 4) ? 4 : cnt_in;
    case (op)
      pmp_pkg::OP_READ, pmp_pkg::OP_WRITE, pmp_pkg::OP_FETCH: begin
        need = (op == pmp_pkg::OP_READ) ? pmp_pkg::PERM_R :
               (op == pmp_pkg::OP_WRITE) ? pmp_pkg::PERM_W : pmp_pkg::PERM_X;
        unm = (op == pmp_pkg::OP_READ) ? pmp_pkg::F_RD_UNMAP :
              (op == pmp_pkg::OP_WRITE) ? pmp_pkg::F_WR_UNMAP : pmp_pkg::F_FE_UNMAP;
        r.ok = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          a = longint'(base) + i;
          if (!page_mapped(a)) begin
            r.flt = unm; r.ok = 1'b0; break;
          end
          if ((page_state[a / PAGE_BYTES][2:0] & need) == 3'b000) begin
            r.flt = unm + 4'd1; r.ok = 1'b0; break;
          end
          if (op == pmp_pkg::OP_WRITE) mem_bytes[a] = wd[8*i +: 8];
          else r.rdata[8*i +: 8] = mem_bytes[a];
          r.ndone++;
        end
      end
      pmp_pkg::OP_DREAD: begin
        r.ok = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          a = longint'(base) + i;
          if (!page_mapped(a)) begin
            r.flt = pmp_pkg::F_DBG_UNMAP; r.ok = 1'b0; break;
          end
          r.rdata[8*i +: 8] = mem_bytes[a];
          r.ndone++;
        end
      end
      pmp_pkg::OP_DWRITE: begin
        r.ok = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          a = longint'(base) + i;
          if (a >= STORE_SIZE) begin
            r.flt = pmp_pkg::F_RANGE; r.ok = 1'b0; break;
          end
          p = a / PAGE_BYTES;
          // A page with no permissions becomes read-write.
          if (page_state[p][2:0] == 3'b000) page_state[p] = {1'b1, pmp_pkg::PERM_RW};
          else page_state[p][pmp_pkg::FLAG_MAPPED] = 1'b1;
          mem_bytes[a] = wd[8*i +: 8];
          r.ndone++;
        end
      end
      pmp_pkg::OP_MAP: begin
        if (sz == 0) r.flt = pmp_pkg::F_EMPTY;
        else begin
          last = longint'(base) + longint'(sz) - 1;
          if (last >= STORE_SIZE) r.flt = pmp_pkg::F_RANGE;
          else begin
            for (p = base / PAGE_BYTES; p <= last / PAGE_BYTES; p++)
              page_state[p] = {1'b1, pm};
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    foreach (page_state[i]) page_state[i] = '0;
    foreach (mem_bytes[i]) mem_bytes[i] = '0;
  end

  assign pending_count = expected_results.size();

  // Predict on accepted command words, compare on result strobes.
  always @(posedge clk) begin
    access_result_t exp_r, got_r;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (done) begin
        got_r = '{read_data, success, fault, bytes_done};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, got_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== got_r) begin
            $display("%0t: mismatch expected data %h ok %b fault %0d done %0d",
                     $time, exp_r.rdata, exp_r.ok, exp_r.flt, exp_r.ndone);
            $display("%0t:          actual   data %h ok %b fault %0d done %0d",
                     $time, read_data, success, fault, bytes_done);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_access(pmp_pkg::op_t'(operation), address,
            byte_count, write_data, region_size, page_perms));
    end
  end

endmodule

### dv/paged_memory_with_permissions_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged memory testbench
// Drives directed and random command words into the paged memory core and
// lets the checker predict and compare every result word. The sender's
// idling changes by phase; the receiver can never stall.
// ----------------------------------------------------------------------------
module paged_memory_with_permissions_core_tb;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned ADDR_BITS  = 20;
  localparam int unsigned STORE_TOP  = 1 << ADDR_BITS;
  localparam int CYCLE_LIMIT = 8_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation = '0;
  logic [31:0] address = '0;
  logic [2:0]  byte_count = '0;
  logic [31:0] write_data = '0;
  logic [31:0] region_size = '0;
  logic [2:0]  page_perms = '0;
  logic        done;
  logic [31:0] read_data;
  logic        success;
  logic [3:0]  fault;
  logic [2:0]  bytes_done;
  int          fail_count, pending_count, result_count;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          sent_count = 0;

  always #5 clk = ~clk;

  paged_memory_with_permissions_core #(.PAGE_BYTES(PAGE_BYTES), .ADDR_BITS(ADDR_BITS)) uut (
    .clk, .rst, .start, .busy, .operation, .address, .byte_count, .write_data,
    .region_size, .page_perms, .done, .read_data, .success, .fault, .bytes_done
  );

  paged_memory_with_permissions_core_checker #(
    .PAGE_BYTES(PAGE_BYTES), .ADDR_BITS(ADDR_BITS)
  ) checker_i (
    .clk, .rst, .start, .busy, .operation, .address, .byte_count, .write_data,
    .region_size, .page_perms, .done, .read_data, .success, .fault, .bytes_done,
    .fail_count, .pending_count, .result_count
  );

  // The run fails if it reaches a generous cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** paged_memory_with_permissions_core: FAILED **");
      $finish;
    end
  end

  // Send one command word, idling before it, and wait for acceptance.
  task automatic send_word(pmp_pkg::op_t op, logic [31:0] a, logic [2:0] n,
      logic [31:0] wd, logic [31:0] sz, logic [2:0] pm);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    address <= a;
    byte_count <= n;
    write_data <= wd;
    region_size <= sz;
    page_perms <= pm;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Addresses mostly inside the store, near page edges and the store top.
  function automatic logic [31:0] pick_address();
    case ($urandom_range(9))
      0: return $urandom();
      1: return STORE_TOP - $urandom_range(6);
      2: return ($urandom_range(255) * PAGE_BYTES) - $urandom_range(3);
      3: return 32'hFFFF_FFFF - $urandom_range(4);
      default: return $urandom_range(STORE_TOP - 1) & 32'h000F_F03F;
    endcase
  endfunction

  task automatic random_word();
    int unsigned sel;
    logic [31:0] a;
    sel = $urandom_range(99);
    a = pick_address();
    if (sel < 12)
      send_word(pmp_pkg::OP_MAP, a, 3'($urandom()), $urandom(),
                ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3 * PAGE_BYTES),
                3'($urandom()));
    else if (sel < 30)
      send_word(pmp_pkg::OP_DWRITE, a, 3'($urandom()), $urandom(), $urandom(),
                3'($urandom()));
    else if (sel < 95)
      send_word(pmp_pkg::op_t'($urandom_range(3)), a, 3'($urandom()), $urandom(),
                $urandom(), 3'($urandom()));
    else
      send_word(pmp_pkg::op_t'($urandom_range(7)), $urandom(), 3'($urandom()),
                $urandom(), $urandom(), 3'($urandom()));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words: unmapped accesses, debug loads, maps and edge cases.
    send_word(pmp_pkg::OP_READ, 32'h0, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_DREAD, 32'h0, 3'd2, '0, '0, '0);
    send_word(pmp_pkg::OP_DWRITE, 32'h0, 3'd7, 32'hFFFF_FFFF, '0, '0);
    send_word(pmp_pkg::OP_READ, 32'h0, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_WRITE, 32'h2, 3'd4, 32'hA5C3_0F11, '0, '0);
    send_word(pmp_pkg::OP_FETCH, 32'h0, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_READ, 32'h0, 3'd0, '0, '0, '0);
    send_word(pmp_pkg::OP_MAP, 32'h1000, '0, '0, 32'd0, pmp_pkg::PERM_X);
    send_word(pmp_pkg::OP_MAP, STORE_TOP - 2, '0, '0, 32'd4, 3'b111);
    send_word(pmp_pkg::OP_MAP, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, 3'b111);
    send_word(pmp_pkg::OP_MAP, 32'h1FFE, '0, '0, 32'd4, pmp_pkg::PERM_X);
    send_word(pmp_pkg::OP_FETCH, 32'h1FFE, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_READ, 32'h1FFE, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_WRITE, 32'h1FFE, 3'd4, 32'h1234_5678, '0, '0);
    send_word(pmp_pkg::OP_MAP, 32'h3000, '0, '0, 32'd1, 3'b000);
    send_word(pmp_pkg::OP_DWRITE, 32'h3001, 3'd2, 32'h0000_BEEF, '0, '0);
    send_word(pmp_pkg::OP_READ, 32'h3000, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_DWRITE, STORE_TOP - 2, 3'd4, 32'hDEAD_BEEF, '0, '0);
    send_word(pmp_pkg::OP_READ, STORE_TOP - 2, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_DREAD, 32'hFFFF_FFFE, 3'd4, '0, '0, '0);
    send_word(pmp_pkg::OP_MAP, 32'h0, '0, '0, 32'd1, 3'b010);
    send_word(pmp_pkg::OP_WRITE, 32'h0, 3'd4, 32'hCAFE_F00D, '0, '0);
    send_word(pmp_pkg::OP_NONE6, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              3'b111);
    send_word(pmp_pkg::OP_NONE7, 32'h0, 3'd4, '0, '0, '0);

    // Random phases with different sender idling.
    idle_pct = 26;
    repeat (430) random_word();
    idle_pct = 69;
    repeat (430) random_word();
    idle_pct = 0;
    repeat (440) random_word();
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d command words and checked %0d result words", sent_count, result_count);
    $display("over reads, writes, fetches, debug accesses and region maps.");
    if (fail_count == 0 && pending_count == 0)
      $display("** paged_memory_with_permissions_core: PASSED **");
    else
      $display("** paged_memory_with_permissions_core: FAILED **");
    $finish;
  end

endmodule
